>>> rtl/ccf_pkg.sv
// Shared types and constants for the chunk frustum cull block.
// Used by ccf_cell, chunk_frustum_cull and ccf_checker; depends on nothing.
`timescale 1ns / 1ps

package ccf_pkg;

    // Plane register layout: a, b, c as signed Q1.12, then d as a signed integer.
    localparam int PLANE_W   = 64;
    localparam int COEF_W    = 14;
    localparam int OFS_W     = 22;
    localparam int FRAC_W    = 12;
    localparam int A_LSB     = 0;
    localparam int B_LSB     = 14;
    localparam int C_LSB     = 28;
    localparam int D_LSB     = 42;

    localparam int NUM_PLANES = 6;
    localparam int IDX_W      = 3;

    localparam int COORD_W     = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_USED_W  = 1 + 2 * COORD_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    localparam int DEF_CHUNK_WIDTH  = 16;
    localparam int DEF_CHUNK_DEPTH  = 16;
    localparam int DEF_CHUNK_HEIGHT = 256;

    // One chunk on its way down the chain of plane cells.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
        logic                      vis;
    } ccf_item_t;

endpackage

>>> rtl/ccf_cell.sv
// One plane cell of the cull chain: holds one plane and tests a chunk against it.
// Two register stages (products, then sum and sign). Depends on ccf_pkg.
`timescale 1ns / 1ps

module ccf_cell #(
    parameter int CHUNK_WIDTH  = ccf_pkg::DEF_CHUNK_WIDTH,
    parameter int CHUNK_DEPTH  = ccf_pkg::DEF_CHUNK_DEPTH,
    parameter int CHUNK_HEIGHT = ccf_pkg::DEF_CHUNK_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ccf_pkg::PLANE_W-1:0]   cfg_plane,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ccf_pkg::ccf_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ccf_pkg::ccf_item_t            out_item
);

    localparam int WB      = $clog2(CHUNK_WIDTH + 1) + 1;
    localparam int DB      = $clog2(CHUNK_DEPTH + 1) + 1;
    localparam int HB      = $clog2(CHUNK_HEIGHT + 1) + 1;
    localparam int AW_W    = ccf_pkg::COEF_W + WB;
    localparam int CD_W    = ccf_pkg::COEF_W + DB;
    localparam int BH_W    = ccf_pkg::COEF_W + HB;
    localparam int PX_W    = AW_W + ccf_pkg::COORD_W;
    localparam int PZ_W    = CD_W + ccf_pkg::COORD_W;
    localparam int DQ_W    = ccf_pkg::OFS_W + ccf_pkg::FRAC_W;
    localparam int M1_W    = (PX_W > PZ_W) ? PX_W : PZ_W;
    localparam int M2_W    = (M1_W > DQ_W) ? M1_W : DQ_W;
    localparam int SUM_W   = M2_W + 3;

    localparam logic signed [WB-1:0] W_S = WB'(CHUNK_WIDTH);
    localparam logic signed [DB-1:0] D_S = DB'(CHUNK_DEPTH);
    localparam logic signed [HB-1:0] H_S = HB'(CHUNK_HEIGHT);

    // Plane in prepared form: x and z slopes scaled by the chunk size, and a bias
    // that picks, per axis, the corner farthest on the inside of the plane.
    logic signed [AW_W-1:0]  aw_reg, aw_next;
    logic signed [CD_W-1:0]  cd_reg, cd_next;
    logic signed [SUM_W-1:0] bias_reg, bias_next;

    logic signed [ccf_pkg::COEF_W-1:0] coef_a, coef_b, coef_c;
    logic signed [ccf_pkg::OFS_W-1:0]  ofs_d;
    logic signed [BH_W-1:0]            bh;

    logic                    v1_reg, v2_reg;
    logic                    ready1, ready2;
    ccf_pkg::ccf_item_t      item1_reg, item2_reg, item2_next;
    logic signed [PX_W-1:0]  px_reg, px_next;
    logic signed [PZ_W-1:0]  pz_reg, pz_next;
    logic signed [SUM_W-1:0] sum;

    always_comb
    begin
        coef_a = cfg_plane[ccf_pkg::A_LSB +: ccf_pkg::COEF_W];
        coef_b = cfg_plane[ccf_pkg::B_LSB +: ccf_pkg::COEF_W];
        coef_c = cfg_plane[ccf_pkg::C_LSB +: ccf_pkg::COEF_W];
        ofs_d  = cfg_plane[ccf_pkg::D_LSB +: ccf_pkg::OFS_W];
        aw_next = AW_W'(coef_a) * AW_W'(W_S);
        cd_next = CD_W'(coef_c) * CD_W'(D_S);
        bh      = BH_W'(coef_b) * BH_W'(H_S);
        bias_next = (SUM_W'(ofs_d) <<< ccf_pkg::FRAC_W)
                  + ((aw_next > 0) ? SUM_W'(aw_next) : SUM_W'(0))
                  + ((cd_next > 0) ? SUM_W'(cd_next) : SUM_W'(0))
                  + ((bh > 0)      ? SUM_W'(bh)      : SUM_W'(0));
    end

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb
    begin
        px_next = PX_W'(aw_reg) * PX_W'(in_item.x);
        pz_next = PZ_W'(cd_reg) * PZ_W'(in_item.z);
        sum     = SUM_W'(px_reg) + SUM_W'(pz_reg) + bias_reg;
        item2_next     = item1_reg;
        // Even the most favorable corner is outside: the whole box is.
        item2_next.vis = item1_reg.vis && !sum[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg   <= '0;
            cd_reg   <= '0;
            bias_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                aw_reg   <= aw_next;
                cd_reg   <= cd_next;
                bias_reg <= bias_next;
            end
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            item1_reg <= in_item;
            px_reg    <= px_next;
            pz_reg    <= pz_next;
        end
        if (ready2 && v1_reg)
            item2_reg <= item2_next;
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

>>> rtl/chunk_frustum_cull.sv
// Top level of the chunk frustum cull block: a chain of six plane cells.
// Depends on ccf_pkg and ccf_cell.
`timescale 1ns / 1ps

// Usage:
// A chunk grid coordinate enters on the s_ stream, one beat per chunk. Its result
// leaves on the m_ stream in the same order, with the visible flag and both
// coordinates echoed back. Planes are loaded through the cfg_ write channel,
// one 64-bit register per beat, with index 0 to 5 for right, left, top, bottom,
// far and near; higher indexes are dropped. cfg_ready is always high. Write the
// planes only while no chunk is in flight.
// The chain has six cells with two register stages each. One chunk per cycle is
// taken and delivered while m_tready stays high; the rate is set by the cell
// pipeline, where a stage advances whenever the stage after it is free or moving.
// When the receiver holds m_tready low, the result waits in the last stage and
// the chain keeps filling its empty stages before s_tready drops.
// Reset clears all plane registers to zero, so every chunk reads as visible
// until planes are written, and empties the chain.
module chunk_frustum_cull #(
    parameter int CHUNK_WIDTH  = ccf_pkg::DEF_CHUNK_WIDTH,
    parameter int CHUNK_DEPTH  = ccf_pkg::DEF_CHUNK_DEPTH,
    parameter int CHUNK_HEIGHT = ccf_pkg::DEF_CHUNK_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ccf_pkg::IN_TDATA_W-1:0]    s_tdata,  // chunk_x, chunk_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccf_pkg::OUT_TDATA_W-1:0]   m_tdata,  // visible, echo_x, echo_z, zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [ccf_pkg::PLANE_W-1:0]       cfg_data
);

    logic               link_valid [0:ccf_pkg::NUM_PLANES];
    logic               link_ready [0:ccf_pkg::NUM_PLANES];
    ccf_pkg::ccf_item_t link_item  [0:ccf_pkg::NUM_PLANES];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        link_valid[0]   = s_tvalid;
        link_item[0].x  = s_tdata[ccf_pkg::COORD_W-1:0];
        link_item[0].z  = s_tdata[2*ccf_pkg::COORD_W-1:ccf_pkg::COORD_W];
        link_item[0].vis = 1'b1;
    end

    assign s_tready = link_ready[0];

    for (genvar i = 0; i < ccf_pkg::NUM_PLANES; i++)
    begin : g_cell
        ccf_cell #(
            .CHUNK_WIDTH (CHUNK_WIDTH),
            .CHUNK_DEPTH (CHUNK_DEPTH),
            .CHUNK_HEIGHT(CHUNK_HEIGHT)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg_we   (cfg_valid && cfg_ready && (cfg_index == ccf_pkg::IDX_W'(i))),
            .cfg_plane(cfg_data),
            .in_valid (link_valid[i]),
            .in_ready (link_ready[i]),
            .in_item  (link_item[i]),
            .out_valid(link_valid[i+1]),
            .out_ready(link_ready[i+1]),
            .out_item (link_item[i+1])
        );
    end

    assign link_ready[ccf_pkg::NUM_PLANES] = m_tready;
    assign m_tvalid = link_valid[ccf_pkg::NUM_PLANES];
    assign m_tdata  = {ccf_pkg::OUT_PAD_W'(0),
                       link_item[ccf_pkg::NUM_PLANES].z,
                       link_item[ccf_pkg::NUM_PLANES].x,
                       link_item[ccf_pkg::NUM_PLANES].vis};

endmodule

>>> rtl/ccf_checker.sv
// Port-level checks for chunk_frustum_cull, attached by the bind below.
// Depends on ccf_pkg.
`timescale 1ns / 1ps

module ccf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ccf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                              cfg_ready
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // With the output stage free or draining, every stage upstream can move, so s_tready is high.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output stage can move");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ccf_pkg::OUT_TDATA_W-1:ccf_pkg::OUT_USED_W] == '0)
        else $error("pad bits of result beat are not zero");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind chunk_frustum_cull ccf_checker u_ccf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);
